@@ design/psa_pkg.sv @@
package psa_pkg;

  // Fixed field widths of one request and one result.
  localparam int HALF_W  = 64;
  localparam int SHIFT_W = 6;
  localparam int PHASE_W = 2;
  localparam int INDEX_W = 7;

  // Phase codes as powers of i, and the index reported for the identity string.
  localparam logic [PHASE_W-1:0] PHASE_POS  = 2'd0;
  localparam logic [PHASE_W-1:0] PHASE_NEG  = 2'd2;
  localparam logic [INDEX_W-1:0] INDEX_NONE = 7'h7F;

  // Pauli letter codes, two bits per site.
  localparam logic [1:0] PAULI_I = 2'd0;
  localparam logic [1:0] PAULI_X = 2'd1;
  localparam logic [1:0] PAULI_Y = 2'd2;
  localparam logic [1:0] PAULI_Z = 2'd3;

  typedef enum logic [2:0] {
    OP_PRODUCT     = 3'd0,
    OP_CONJ_SIGN   = 3'd1,
    OP_LEFTMOST    = 3'd2,
    OP_TARGET_MASK = 3'd3,
    OP_SHIFT       = 3'd4,
    OP_TENSOR      = 3'd5
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [HALF_W-1:0]  a_low;
    logic [HALF_W-1:0]  a_high;
    logic [HALF_W-1:0]  b_low;
    logic [HALF_W-1:0]  b_high;
    logic [SHIFT_W-1:0] site_shift;
  } req_t;

  typedef struct packed {
    logic [HALF_W-1:0]         res_low;
    logic [HALF_W-1:0]         res_high;
    logic [PHASE_W-1:0]        phase;
    logic signed [INDEX_W-1:0] site_index;
    logic                      error;
  } res_t;

endpackage

@@ design/psa_phase.sv @@
module psa_phase (
  input  logic [psa_pkg::HALF_W-1:0]  a_low,
  input  logic [psa_pkg::HALF_W-1:0]  a_high,
  input  logic [psa_pkg::HALF_W-1:0]  b_low,
  input  logic [psa_pkg::HALF_W-1:0]  b_high,
  output logic [psa_pkg::PHASE_W-1:0] product_phase,
  output logic                        y_parity
);
  import psa_pkg::*;

  localparam int SITES = HALF_W;  // both halves, 32 sites each at most

  // Phase contributed by one site of a.b: +1 for XY, YZ, ZX and +3 for the reverse.
  function automatic logic [PHASE_W-1:0] site_phase(input logic [1:0] pa, input logic [1:0] pb);
    logic [PHASE_W-1:0] ph;
    begin
      ph = 2'd0;
      if (pa != PAULI_I && pb != PAULI_I && pa != pb) begin
        if ((pa == PAULI_X && pb == PAULI_Y) || (pa == PAULI_Y && pb == PAULI_Z) ||
            (pa == PAULI_Z && pb == PAULI_X)) begin
          ph = 2'd1;
        end else begin
          ph = 2'd3;
        end
      end
      site_phase = ph;
    end
  endfunction

  logic [2*HALF_W-1:0]  a_all;
  logic [2*HALF_W-1:0]  b_all;
  logic [PHASE_W-1:0]   node [1:2*SITES-1];
  logic [SITES-1:0]     y_flag;

  assign a_all = {a_high, a_low};
  assign b_all = {b_high, b_low};

  // Heap-ordered adder tree, mod 4, over the per-site phases.
  always_comb begin
    for (int s = 0; s < SITES; s++) begin
      node[SITES + s] = site_phase(a_all[2*s +: 2], b_all[2*s +: 2]);
      y_flag[s]       = (a_all[2*s +: 2] == PAULI_Y);
    end
    for (int i = SITES - 1; i >= 1; i--) begin
      node[i] = node[2*i] + node[2*i + 1];
    end
  end

  assign product_phase = node[1];
  assign y_parity      = ^y_flag;

endmodule

@@ design/psa_ops.sv @@
module psa_ops #(
  parameter int SITES_PER_HALF = 32
) (
  input  psa_pkg::req_t req,
  output psa_pkg::res_t res
);
  import psa_pkg::*;

  localparam int                HALF_BITS = 2 * SITES_PER_HALF;
  localparam logic [HALF_W-1:0] HALF_MASK = {HALF_W{1'b1}} >> (HALF_W - HALF_BITS);
  localparam logic [INDEX_W-1:0] SPH_IDX  = INDEX_W'(SITES_PER_HALF);

  logic [HALF_W-1:0]         al, ah, bl, bh;
  logic [SITES_PER_HALF-1:0] sites_lo, sites_hi;
  logic [INDEX_W-1:0]        lo_top, hi_top;
  logic [INDEX_W-1:0]        sh_bits, keep_bits;
  logic [HALF_W-1:0]         sh_low, sh_high;
  logic                      shift_bad;
  logic [PHASE_W-1:0]        product_phase;
  logic                      y_parity;

  // Bits above the configured half width are ignored.
  assign al = req.a_low  & HALF_MASK;
  assign ah = req.a_high & HALF_MASK;
  assign bl = req.b_low  & HALF_MASK;
  assign bh = req.b_high & HALF_MASK;

  // Non-identity flags per site and the topmost such site in each half.
  always_comb begin
    lo_top = INDEX_NONE;
    hi_top = '0;
    for (int k = 0; k < SITES_PER_HALF; k++) begin
      sites_lo[k] = |al[2*k +: 2];
      sites_hi[k] = |ah[2*k +: 2];
      if (sites_lo[k]) begin
        lo_top = INDEX_W'(k);
      end
      if (sites_hi[k]) begin
        hi_top = INDEX_W'(k);
      end
    end
  end

  // Left shift by whole sites, with the carry from the low half into the high half.
  assign sh_bits   = {1'b0, req.site_shift} << 1;
  assign keep_bits = INDEX_W'(HALF_BITS) - sh_bits;
  assign sh_low    = (al << sh_bits) & HALF_MASK;
  assign sh_high   = ((ah << sh_bits) | (al >> keep_bits)) & HALF_MASK;
  assign shift_bad = (req.site_shift == '0) || ({1'b0, req.site_shift} >= SPH_IDX);

  psa_phase u_phase (
    .a_low         (al),
    .a_high        (ah),
    .b_low         (bl),
    .b_high        (bh),
    .product_phase (product_phase),
    .y_parity      (y_parity)
  );

  // Operation select; fields an operation does not define stay zero.
  always_comb begin
    res = '0;
    case (req.op)
      OP_PRODUCT: begin
        res.res_low  = al ^ bl;
        res.res_high = ah ^ bh;
        res.phase    = product_phase;
      end
      OP_CONJ_SIGN: begin
        res.phase = y_parity ? PHASE_NEG : PHASE_POS;
      end
      OP_LEFTMOST: begin
        res.site_index = (ah != '0) ? (SPH_IDX + hi_top) : lo_top;
      end
      OP_TARGET_MASK: begin
        res.res_low = HALF_W'(sites_lo) | (HALF_W'(sites_hi) << SITES_PER_HALF);
      end
      OP_SHIFT, OP_TENSOR: begin
        if (shift_bad) begin
          res.error = 1'b1;
        end else if (req.op == OP_TENSOR) begin
          res.res_low  = sh_low | bl;
          res.res_high = sh_high | bh;
        end else begin
          res.res_low  = sh_low;
          res.res_high = sh_high;
        end
      end
      default: begin
        res = '0;
      end
    endcase
  end

endmodule

@@ design/pauli_string_alu_unit.sv @@
// Pauli string ALU. Each beat carries two Pauli strings of up to 64 sites (two bits per
// site, I=0 X=1 Y=2 Z=3, low half holding sites 0 to SITES_PER_HALF-1) and an opcode on
// s_tuser: 0 product with phase, 1 conjugation sign, 2 leftmost non-identity site,
// 3 target site mask, 4 shift left by site_shift sites, 5 tensor product; codes 6 and 7
// return all zeros. A shift outside 1 to SITES_PER_HALF-1 returns a zero string with the
// error flag on m_tuser. The block is a two-register pipeline: the beat is captured in an
// input register, all operations are evaluated in one pass of logic, and the result sits
// in an output register. The block takes one beat per cycle; s_tready only drops when
// both registers are full and m_tready is low.
module pauli_string_alu_unit #(
  parameter int SITES_PER_HALF = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // a_low[63:0], a_high[127:64], b_low[191:128], b_high[255:192],
  // site_shift[261:256], zero fill [263:262]
  input  logic [263:0] s_tdata,
  // op[2:0]
  input  logic [2:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // res_low[63:0], res_high[127:64], phase[129:128], site_index[136:130],
  // zero fill [143:137]
  output logic [143:0] m_tdata,
  // error[0]
  output logic [0:0]   m_tuser
);
  import psa_pkg::*;

  logic in_valid;
  logic out_valid;
  req_t req;
  res_t res;
  res_t res_next;
  logic out_load;

  // The output register loads whenever the input register holds a beat and it is empty or being drained.
  assign out_load = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || !out_valid || m_tready;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      req.op         <= op_t'(s_tuser);
      req.a_low      <= s_tdata[63:0];
      req.a_high     <= s_tdata[127:64];
      req.b_low      <= s_tdata[191:128];
      req.b_high     <= s_tdata[255:192];
      req.site_shift <= s_tdata[261:256];
    end
  end

  psa_ops #(
    .SITES_PER_HALF (SITES_PER_HALF)
  ) u_ops (
    .req (req),
    .res (res_next)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res <= res_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {7'b0, res.site_index, res.phase, res.res_high, res.res_low};
  assign m_tuser  = res.error;

  // An error result never carries a string, a phase or an index.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && res.error |-> res.res_low == '0 && res.res_high == '0 &&
                               res.phase == '0 && res.site_index == '0)
    else $error("error result carries data");

  // A nonzero site index excludes a high string half, a phase or the error flag in the same result.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && res.site_index != '0 |-> res.res_high == '0 && res.phase == '0 && !res.error)
    else $error("site index mixed with other result fields");

  // With the output register empty, a held item moves forward on the next edge.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !out_valid |=> out_valid)
    else $error("pipeline failed to advance");

  // An empty output register never blocks the input side.
  assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> s_tready)
    else $error("input stalled with empty output register");

endmodule
